// ----- rtl/tsmu_pkg.sv -----
`timescale 1ns / 1ps
package tsmu_pkg;

  typedef enum logic [3:0] {
    FN_CEIL     = 4'd0,
    FN_FLOOR    = 4'd1,
    FN_ROUND    = 4'd2,
    FN_TRUNC    = 4'd3,
    FN_ISINF    = 4'd4,
    FN_ISNAN    = 4'd5,
    FN_ISFINITE = 4'd6,
    FN_ABS      = 4'd7,
    FN_SIGN     = 4'd8,
    FN_AND      = 4'd9,
    FN_OR       = 4'd10,
    FN_XOR      = 4'd11,
    FN_NOT      = 4'd12,
    FN_SHL      = 4'd13,
    FN_SHR      = 4'd14,
    FN_BAD      = 4'd15
  } func_e;

  localparam logic [2:0] KIND_INT  = 3'd0;
  localparam logic [2:0] KIND_UINT = 3'd1;
  localparam logic [2:0] KIND_DBL  = 3'd2;
  localparam logic [2:0] KIND_BOOL = 3'd3;
  localparam logic [2:0] KIND_ERR  = 3'd4;
  localparam logic [2:0] KIND_UNK  = 3'd5;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_TYPE  = 2'd1;
  localparam logic [1:0] ERR_OVF   = 2'd2;
  localparam logic [1:0] ERR_INVAL = 2'd3;

  localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;
  localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;

  typedef struct packed {
    logic [3:0]  func;
    logic [2:0]  kind_a;
    logic [63:0] value_a;
    logic [2:0]  kind_b;
    logic [63:0] value_b;
  } req_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [63:0] result_value;
    logic [1:0]  error_code;
  } rsp_t;

endpackage

// ----- rtl/tsmu_req_if.sv -----
`timescale 1ns / 1ps
interface tsmu_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  func;
  logic [2:0]  kind_a;
  logic [63:0] value_a;
  logic [2:0]  kind_b;
  logic [63:0] value_b;
  modport source (output valid, func, kind_a, value_a, kind_b, value_b, input ready);
  modport sink (input valid, func, kind_a, value_a, kind_b, value_b, output ready);
endinterface

// ----- rtl/tsmu_rsp_if.sv -----
`timescale 1ns / 1ps
interface tsmu_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [63:0] result_value;
  logic [1:0]  error_code;
  modport source (output valid, result_kind, result_value, error_code, input ready);
  modport sink (input valid, result_kind, result_value, error_code, output ready);
endinterface

// ----- rtl/tsmu_round.sv -----
`timescale 1ns / 1ps
module tsmu_round (
  input  logic [63:0] x_i,
  input  logic [1:0]  mode_i,
  output logic [63:0] y_o
);
  logic [10:0] ef;
  logic [11:0] e;
  logic [5:0]  fb;
  logic [63:0] mask;
  logic [63:0] tr;
  logic        up;
  logic        half;

  assign ef = x_i[62:52];
  assign e  = {1'b0, ef} - 12'd1023;
  // fraction bits below the binary point: 52 - e, valid for 0 <= e < 52
  assign fb   = 6'(6'd52 - e[5:0]);
  assign mask = (64'd1 << fb) - 64'd1;
  assign tr   = x_i & ~mask;
  assign half = |(x_i & (mask >> 1) ^ x_i & mask) ;

  always_comb begin
    up = 1'b0;
    unique case (mode_i)
      2'(tsmu_pkg::FN_CEIL): up = !x_i[63];
      2'(tsmu_pkg::FN_FLOOR): up = x_i[63];
      2'(tsmu_pkg::FN_ROUND): up = half;
      default: up = 1'b0;
    endcase
    if (ef == 11'h7FF) begin
      y_o = (|x_i[51:0]) ? (x_i | tsmu_pkg::QUIET_BIT) : x_i;
    end else if (x_i[62:0] == 63'd0) begin
      y_o = x_i;
    end else if (ef >= 11'd1075) begin
      y_o = x_i;
    end else if (ef < 11'd1023) begin
      if (mode_i == 2'(tsmu_pkg::FN_ROUND)) up = (ef == 11'd1022);
      y_o = {x_i[63], 63'd0} | (up ? tsmu_pkg::ONE_BITS : 64'd0);
    end else if ((x_i & mask) == 64'd0) begin
      y_o = x_i;
    end else begin
      y_o = up ? tr + mask + 64'd1 : tr;
    end
  end
endmodule

// ----- rtl/tsmu_core.sv -----
`timescale 1ns / 1ps
module tsmu_core (
  input  tsmu_pkg::req_t req_i,
  output tsmu_pkg::rsp_t rsp_o
);
  logic [63:0] va, vb, rnd;
  logic [2:0]  ka, kb;
  logic        a_num, nan_a, exp_all;
  tsmu_pkg::func_e fn;

  assign fn = tsmu_pkg::func_e'(req_i.func);
  assign ka = req_i.kind_a;
  assign kb = req_i.kind_b;
  assign va = req_i.value_a;
  assign vb = req_i.value_b;
  assign a_num   = (ka == tsmu_pkg::KIND_INT) || (ka == tsmu_pkg::KIND_UINT);
  assign exp_all = (va[62:52] == 11'h7FF);
  assign nan_a   = exp_all && (|va[51:0]);

  tsmu_round u_round (.x_i(va), .mode_i(req_i.func[1:0]), .y_o(rnd));

  always_comb begin
    rsp_o = '{tsmu_pkg::KIND_ERR, 64'd0, tsmu_pkg::ERR_TYPE};
    if (fn == tsmu_pkg::FN_BAD) begin
      rsp_o = '{tsmu_pkg::KIND_ERR, 64'd0, tsmu_pkg::ERR_TYPE};
    end else if (ka == tsmu_pkg::KIND_ERR || ka == tsmu_pkg::KIND_UNK) begin
      rsp_o = '{ka, va, tsmu_pkg::ERR_NONE};
    end else if (fn >= tsmu_pkg::FN_AND && fn != tsmu_pkg::FN_NOT &&
                 (kb == tsmu_pkg::KIND_ERR || kb == tsmu_pkg::KIND_UNK)) begin
      rsp_o = '{kb, vb, tsmu_pkg::ERR_NONE};
    end else begin
      unique case (fn)
        tsmu_pkg::FN_CEIL, tsmu_pkg::FN_FLOOR, tsmu_pkg::FN_ROUND,
        tsmu_pkg::FN_TRUNC: begin
          if (ka == tsmu_pkg::KIND_DBL) rsp_o = '{tsmu_pkg::KIND_DBL, rnd, tsmu_pkg::ERR_NONE};
        end
        tsmu_pkg::FN_ISINF: begin
          if (ka == tsmu_pkg::KIND_DBL)
            rsp_o = '{tsmu_pkg::KIND_BOOL, {63'd0, exp_all && !(|va[51:0])},
                      tsmu_pkg::ERR_NONE};
        end
        tsmu_pkg::FN_ISNAN: begin
          if (ka == tsmu_pkg::KIND_DBL)
            rsp_o = '{tsmu_pkg::KIND_BOOL, {63'd0, nan_a}, tsmu_pkg::ERR_NONE};
        end
        tsmu_pkg::FN_ISFINITE: begin
          if (ka == tsmu_pkg::KIND_DBL)
            rsp_o = '{tsmu_pkg::KIND_BOOL, {63'd0, !exp_all}, tsmu_pkg::ERR_NONE};
        end
        tsmu_pkg::FN_ABS: begin
          if (ka == tsmu_pkg::KIND_INT) begin
            if (va == tsmu_pkg::SIGN_BIT)
              rsp_o = '{tsmu_pkg::KIND_ERR, 64'd0, tsmu_pkg::ERR_OVF};
            else
              rsp_o = '{ka, va[63] ? 64'd0 - va : va, tsmu_pkg::ERR_NONE};
          end else if (ka == tsmu_pkg::KIND_UINT) begin
            rsp_o = '{ka, va, tsmu_pkg::ERR_NONE};
          end else if (ka == tsmu_pkg::KIND_DBL) begin
            rsp_o = '{ka, {1'b0, va[62:0]}, tsmu_pkg::ERR_NONE};
          end
        end
        tsmu_pkg::FN_SIGN: begin
          if (ka == tsmu_pkg::KIND_INT)
            rsp_o = '{ka, va[63] ? '1 : {63'd0, |va}, tsmu_pkg::ERR_NONE};
          else if (ka == tsmu_pkg::KIND_UINT)
            rsp_o = '{ka, {63'd0, |va}, tsmu_pkg::ERR_NONE};
          else if (ka == tsmu_pkg::KIND_DBL)
            rsp_o = '{ka, nan_a ? va : (va[62:0] == 63'd0) ? 64'd0
                      : ({va[63], 63'd0} | tsmu_pkg::ONE_BITS), tsmu_pkg::ERR_NONE};
        end
        tsmu_pkg::FN_NOT: begin
          if (a_num) rsp_o = '{ka, ~va, tsmu_pkg::ERR_NONE};
        end
        tsmu_pkg::FN_AND, tsmu_pkg::FN_OR, tsmu_pkg::FN_XOR: begin
          if (a_num && ka == kb)
            rsp_o = '{ka, (fn == tsmu_pkg::FN_AND) ? (va & vb) :
                      (fn == tsmu_pkg::FN_OR) ? (va | vb) : (va ^ vb), tsmu_pkg::ERR_NONE};
        end
        tsmu_pkg::FN_SHL, tsmu_pkg::FN_SHR: begin
          if (kb != tsmu_pkg::KIND_INT)
            rsp_o = '{tsmu_pkg::KIND_ERR, 64'd0, tsmu_pkg::ERR_TYPE};
          else if (vb[63])
            rsp_o = '{tsmu_pkg::KIND_ERR, 64'd0, tsmu_pkg::ERR_INVAL};
          else if (a_num)
            rsp_o = '{ka, (|vb[62:6]) ? 64'd0 : (fn == tsmu_pkg::FN_SHL) ?
                      (va << vb[5:0]) : (va >> vb[5:0]), tsmu_pkg::ERR_NONE};
        end
        default: rsp_o = '{tsmu_pkg::KIND_ERR, 64'd0, tsmu_pkg::ERR_TYPE};
      endcase
    end
  end
endmodule

// ----- rtl/typed_scalar_math_unit.sv -----
`timescale 1ns / 1ps
// Typed scalar math unit.
// req_i carries an opcode and two tagged 64-bit operands; rsp_o returns one
// tagged result with an error code for every request taken.
// A request is taken when valid and ready are both high on a rising edge.
// It is registered, evaluated in one combinational pass (rounding, tests,
// abs, sign, bitwise ops, shifts) and the response is registered.
// Path: the request is captured in the input register and its result is
// loaded into the output register when the output stage advances.
// Throughput: one request per cycle; the two register stages form a pipe
// that advances whenever the output stage is empty or being drained.
// A stalled receiver holds the output register, and ready drops once both
// stages are full, so no response is lost or repeated.
// Reset (rst_ni low, asynchronous) clears both stage valid flags; the block
// then holds no work and raises ready.
module typed_scalar_math_unit (
  input  logic clk_i,
  input  logic rst_ni,
  tsmu_req_if.sink   req_i,
  tsmu_rsp_if.source rsp_o
);
  tsmu_pkg::req_t in_q;
  tsmu_pkg::rsp_t out_q, out_d;
  logic in_vld_q, out_vld_q, out_adv, in_adv;

  assign out_adv = !out_vld_q || rsp_o.ready;
  assign in_adv  = !in_vld_q || out_adv;
  assign req_i.ready = in_adv;

  tsmu_core u_core (.req_i(in_q), .rsp_o(out_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_adv) in_vld_q <= req_i.valid;
      if (out_adv) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && req_i.valid)
      in_q <= '{req_i.func, req_i.kind_a, req_i.value_a, req_i.kind_b, req_i.value_b};
    if (out_adv && in_vld_q) out_q <= out_d;
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.result_kind  = out_q.result_kind;
  assign rsp_o.result_value = out_q.result_value;
  assign rsp_o.error_code   = out_q.error_code;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !rsp_o.ready |=> out_vld_q && $stable(out_q))
    else $error("response dropped under stall");
  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_adv |=> out_vld_q)
    else $error("request lost between stages");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> in_vld_q && out_vld_q)
    else $error("ready low with free stage");
endmodule
